@@ hdl/fpdaf_pkg.sv @@
// Shared types and character codes for the fixed-point decimal ASCII formatter.
package fpdaf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOW,
    ST_SKIP,
    ST_SPACE,
    ST_AXIS,
    ST_ZERO,
    ST_MINUS,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

endpackage

@@ hdl/fixed_point_decimal_ascii_formatter.sv @@
// Top level: fixed-point value to decimal ASCII axis word, one character per output beat.
//
// Input channel (in_valid_i / in_stall_o): one request carries an axis letter,
// a fraction digit count and a scaled signed value. A request is taken when
// in_valid_i is high and in_stall_o is low; in_stall_o stays high from then
// until the last character of that request has been loaded into the output
// register.
// Output channel (out_valid_o / out_stall_i): one ASCII character per beat,
// last_char_o marks the final character of a request's text.
// Per request: shift-and-add-3 conversion over the VALUE_BITS input bits through
// one shared BCD step unit, then a scan upward for the lowest kept fraction
// digit, then a scan down over leading zeros (both scans are skipped for a
// zero value), then one character per cycle (3 to 19 characters at 48 bits)
// while the receiver does not stall. The block returns to idle after the last
// character load and only then takes the next request.
// A stall on the output holds the character register and freezes the
// character sequencer; the conversion phases run on regardless.
// Reset clears the sequencer to idle and drops out_valid_o.
// frac_digits above MAX_FRAC_DIGITS is clamped.
module fixed_point_decimal_ascii_formatter #(
  parameter int VALUE_BITS      = 48,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            axis_letter_i,
  input  logic [3:0]            frac_digits_i,
  input  logic [VALUE_BITS-1:0] scaled_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_char_o
);

  // decimal digits needed for the magnitude, at least enough for fraction padding
  localparam int DEC_DIGITS = (VALUE_BITS * 301) / 1000 + 2;
  localparam int NDIG = (DEC_DIGITS > MAX_FRAC_DIGITS + 1) ? DEC_DIGITS
                                                           : MAX_FRAC_DIGITS + 1;
  localparam int IDXW = $clog2(NDIG);
  localparam int CNTW = $clog2(VALUE_BITS);

  fpdaf_pkg::state_e state_q, state_d;

  logic [7:0]            axis_q;
  logic [3:0]            frac_q;
  logic                  neg_q;
  logic                  zero_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [NDIG*4-1:0]     bcd_q;
  logic [NDIG*4-1:0]     bcd_step;
  logic [CNTW-1:0]       cnt_q;
  logic [IDXW-1:0]       idx_q;
  logic [IDXW-1:0]       keep_q;   // lowest nonzero fraction position, else frac_q

  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  last_q;

  logic                  in_acc;
  logic                  can_load;
  logic [3:0]            frac_sat;
  logic [VALUE_BITS-1:0] mag_in;
  logic [3:0]            dig;
  logic [IDXW-1:0]       frac_ext;
  logic                  idx_ge_frac;
  logic                  has_frac;
  logic                  emit_valid;
  logic [7:0]            emit_char;
  logic                  emit_last;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign can_load = !out_valid_q || !out_stall_i;

  assign frac_sat = (frac_digits_i > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS)
                                                         : frac_digits_i;
  // most negative value wraps to 2^(VALUE_BITS-1), exact as unsigned
  assign mag_in = scaled_value_i[VALUE_BITS-1] ? (~scaled_value_i + 1'b1)
                                               : scaled_value_i;

  assign dig         = bcd_q[{idx_q, 2'b00} +: 4];
  assign frac_ext    = IDXW'(frac_q);
  assign idx_ge_frac = idx_q >= frac_ext;
  assign has_frac    = keep_q < frac_ext;

  fpdaf_dabble #(
    .NDIG (NDIG)
  ) u_dabble (
    .bcd_i (bcd_q),
    .bit_i (mag_q[VALUE_BITS-1]),
    .bcd_o (bcd_step)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpdaf_pkg::ST_IDLE: begin
        if (in_acc) state_d = fpdaf_pkg::ST_CONV;
      end
      fpdaf_pkg::ST_CONV: begin
        // a zero value has no digit to find, so the scans are skipped
        if (cnt_q == CNTW'(VALUE_BITS - 1)) begin
          if (zero_q) state_d = fpdaf_pkg::ST_SPACE;
          else state_d = fpdaf_pkg::ST_LOW;
        end
      end
      fpdaf_pkg::ST_LOW: begin
        if (!(idx_q < frac_ext && dig == 4'd0)) state_d = fpdaf_pkg::ST_SKIP;
      end
      fpdaf_pkg::ST_SKIP: begin
        if (!(idx_ge_frac && dig == 4'd0)) state_d = fpdaf_pkg::ST_SPACE;
      end
      fpdaf_pkg::ST_SPACE: begin
        if (can_load) state_d = fpdaf_pkg::ST_AXIS;
      end
      fpdaf_pkg::ST_AXIS: begin
        if (can_load) begin
          if (zero_q) state_d = fpdaf_pkg::ST_ZERO;
          else if (neg_q) state_d = fpdaf_pkg::ST_MINUS;
          else if (idx_ge_frac) state_d = fpdaf_pkg::ST_INT;
          else state_d = fpdaf_pkg::ST_POINT;
        end
      end
      fpdaf_pkg::ST_ZERO: begin
        if (can_load) state_d = fpdaf_pkg::ST_IDLE;
      end
      fpdaf_pkg::ST_MINUS: begin
        if (can_load) begin
          if (idx_ge_frac) state_d = fpdaf_pkg::ST_INT;
          else state_d = fpdaf_pkg::ST_POINT;
        end
      end
      fpdaf_pkg::ST_INT: begin
        if (can_load && idx_q == frac_ext) begin
          if (has_frac) state_d = fpdaf_pkg::ST_POINT;
          else state_d = fpdaf_pkg::ST_IDLE;
        end
      end
      fpdaf_pkg::ST_POINT: begin
        if (can_load) state_d = fpdaf_pkg::ST_FRAC;
      end
      fpdaf_pkg::ST_FRAC: begin
        if (can_load && idx_q == keep_q) state_d = fpdaf_pkg::ST_IDLE;
      end
      default: state_d = fpdaf_pkg::ST_IDLE;
    endcase
  end

  // character produced in each emitting state
  always_comb begin
    emit_valid = 1'b0;
    emit_char  = fpdaf_pkg::CH_SPACE;
    emit_last  = 1'b0;
    in_stall_o = (state_q != fpdaf_pkg::ST_IDLE);
    unique case (state_q)
      fpdaf_pkg::ST_SPACE: begin
        emit_valid = 1'b1;
      end
      fpdaf_pkg::ST_AXIS: begin
        emit_valid = 1'b1;
        emit_char  = axis_q;
      end
      fpdaf_pkg::ST_ZERO: begin
        emit_valid = 1'b1;
        emit_char  = fpdaf_pkg::CH_ZERO;
        emit_last  = 1'b1;
      end
      fpdaf_pkg::ST_MINUS: begin
        emit_valid = 1'b1;
        emit_char  = fpdaf_pkg::CH_MINUS;
      end
      fpdaf_pkg::ST_INT: begin
        emit_valid = 1'b1;
        emit_char  = fpdaf_pkg::CH_ZERO | {4'd0, dig};
        emit_last  = (idx_q == frac_ext) && !has_frac;
      end
      fpdaf_pkg::ST_POINT: begin
        emit_valid = 1'b1;
        emit_char  = fpdaf_pkg::CH_POINT;
      end
      fpdaf_pkg::ST_FRAC: begin
        emit_valid = 1'b1;
        emit_char  = fpdaf_pkg::CH_ZERO | {4'd0, dig};
        emit_last  = (idx_q == keep_q);
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpdaf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (can_load) out_valid_q <= emit_valid;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (can_load) begin
      out_char_q <= emit_char;
      last_q     <= emit_last;
    end
    unique case (state_q)
      fpdaf_pkg::ST_IDLE: begin
        if (in_acc) begin
          axis_q <= axis_letter_i;
          frac_q <= frac_sat;
          neg_q  <= scaled_value_i[VALUE_BITS-1];
          zero_q <= (scaled_value_i == '0);
          mag_q  <= mag_in;
          bcd_q  <= '0;
          cnt_q  <= '0;
          idx_q  <= '0;
        end
      end
      fpdaf_pkg::ST_CONV: begin
        bcd_q <= bcd_step;
        mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      fpdaf_pkg::ST_LOW: begin
        if (idx_q < frac_ext && dig == 4'd0) begin
          idx_q <= idx_q + 1'b1;
        end else begin
          keep_q <= idx_q;
          idx_q  <= IDXW'(NDIG - 1);
        end
      end
      fpdaf_pkg::ST_SKIP: begin
        if (idx_ge_frac && dig == 4'd0) idx_q <= idx_q - 1'b1;
      end
      fpdaf_pkg::ST_INT, fpdaf_pkg::ST_FRAC: begin
        if (can_load) idx_q <= idx_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

endmodule

@@ hdl/fpdaf_dabble.sv @@
// One shift-and-add-3 step of a binary to BCD conversion over all digits.
module fpdaf_dabble #(
  parameter int NDIG = 16
) (
  input  logic [NDIG*4-1:0] bcd_i,
  input  logic              bit_i,
  output logic [NDIG*4-1:0] bcd_o
);

  logic [NDIG*4-1:0] adj;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_i[k*4 +: 4] >= 4'd5) begin
        adj[k*4 +: 4] = bcd_i[k*4 +: 4] + 4'd3;
      end else begin
        adj[k*4 +: 4] = bcd_i[k*4 +: 4];
      end
    end
  end

  // digits that overflow past the top are always zero by sizing
  assign bcd_o = {adj[NDIG*4-2:0], bit_i};

endmodule

@@ tb/sv/fixed_point_decimal_ascii_formatter_tb.sv @@
// Self-checking testbench for the fixed-point decimal ASCII formatter.
module fixed_point_decimal_ascii_formatter_tb;

  localparam int VALUE_BITS      = 48;
  localparam int MAX_FRAC_DIGITS = 9;
  // text can run up to 19 chars, each may sit through receiver stalls
  localparam int DRAIN_CYCLES    = 200;

  // One request as queued for the driver, with the idling it runs under.
  typedef struct {
    logic [7:0]            axis;
    logic [3:0]            frac;
    logic [VALUE_BITS-1:0] value;
    int                    idle_pct;
    int                    stall_pct;
    bit                    drain_first;  // hold off until all text is out
  } request_t;

  // One expected character of an axis word.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } axis_char_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            axis_letter_i;
  logic [3:0]            frac_digits_i;
  logic [VALUE_BITS-1:0] scaled_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            out_char_o;
  logic                  last_char_o;

  request_t   req_q[$];     // requests waiting to be driven
  axis_char_t text_q[$];    // characters still owed by the block
  int         stall_pct;    // receiver stall rate of the current phase
  int         mismatches;

  // knobs used while the stimulus is built
  int cur_idle;
  int cur_stall;
  bit drain_next;

  fixed_point_decimal_ascii_formatter #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .axis_letter_i (axis_letter_i),
    .frac_digits_i (frac_digits_i),
    .scaled_value_i(scaled_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_char_o   (last_char_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Expected text of one request: space, letter, then 0 for a zero value, else sign
  // if negative, integer part (dropped when zero), point and fraction less trailing zeros.
  task automatic predict_axis_word(input request_t r);
    logic [63:0] mag;
    longint      sval;
    bit          neg;
    int          dig[24];
    int          n;
    int          fn;
    int          keep;
    int          i;
    logic [7:0]  word[$];
    axis_char_t  c;
    sval = {{(64-VALUE_BITS){r.value[VALUE_BITS-1]}}, r.value};
    neg  = r.value[VALUE_BITS-1];
    // 64-bit magnitude keeps the most negative value exact
    mag  = neg ? 64'(-sval) : 64'(sval);
    fn   = (r.frac > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(r.frac);
    word.push_back(fpdaf_pkg::CH_SPACE);
    word.push_back(r.axis);
    if (mag == 64'd0) begin
      word.push_back(fpdaf_pkg::CH_ZERO);
    end else begin
      n = 0;
      while (mag != 64'd0) begin
        dig[n] = int'(mag % 64'd10);
        mag    = mag / 64'd10;
        n++;
      end
      while (n < fn) begin
        dig[n] = 0;
        n++;
      end
      if (neg) word.push_back(fpdaf_pkg::CH_MINUS);
      for (i = n; i > fn; i--) word.push_back(8'(fpdaf_pkg::CH_ZERO + dig[i-1]));
      keep = 0;
      while (keep < fn && dig[keep] == 0) keep++;
      if (keep < fn) begin
        word.push_back(fpdaf_pkg::CH_POINT);
        for (i = fn; i > keep; i--) word.push_back(8'(fpdaf_pkg::CH_ZERO + dig[i-1]));
      end
    end
    foreach (word[k]) begin
      c.ch   = word[k];
      c.last = (k == word.size() - 1);
      text_q.push_back(c);
    end
  endtask

  task automatic add_request(input logic [7:0] axis, input logic [3:0] frac,
                             input logic [VALUE_BITS-1:0] value);
    request_t r;
    r.axis        = axis;
    r.frac        = frac;
    r.value       = value;
    r.idle_pct    = cur_idle;
    r.stall_pct   = cur_stall;
    r.drain_first = drain_next;
    req_q.push_back(r);
    drain_next = 1'b0;
  endtask

  // Random scaled value: full width, near zero, with trailing zeros, or of random size up to 32 bits.
  function automatic logic [VALUE_BITS-1:0] random_value();
    longint m;
    int     s;
    int     k;
    case ($urandom_range(0, 3))
      0: return VALUE_BITS'({$urandom, $urandom});
      1: begin
        s = $urandom_range(0, 2000);
        s = s - 1000;
        return VALUE_BITS'(s);
      end
      2: begin
        m = $urandom_range(0, 99999);
        k = $urandom_range(1, 9);
        repeat (k) m = m * 10;
        if ($urandom_range(0, 1) == 1) m = -m;
        return VALUE_BITS'(m);
      end
      default: begin
        m = longint'($urandom >> $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) m = -m;
        return VALUE_BITS'(m);
      end
    endcase
  endfunction

  // Driver: the next request goes out once the previous one is taken.
  // A request marked drain_first waits for an idle cycle with no text owed,
  // so it only starts once the block has fully drained.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t nxt;
    bit       ready;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      axis_letter_i  <= '0;
      frac_digits_i  <= '0;
      scaled_value_i <= '0;
      stall_pct      <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      ready = req_q.size() != 0;
      if (ready && req_q[0].drain_first)
        ready = !in_valid_i && text_q.size() == 0;
      if (ready && $urandom_range(0, 99) >= req_q[0].idle_pct) begin
        nxt = req_q.pop_front();
        in_valid_i     <= 1'b1;
        axis_letter_i  <= nxt.axis;
        frac_digits_i  <= nxt.frac;
        scaled_value_i <= nxt.value;
        stall_pct      <= nxt.stall_pct;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on request accept, checks every accepted character,
  // and drives the receiver's stall.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    request_t   seen;
    axis_char_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        seen.axis  = axis_letter_i;
        seen.frac  = frac_digits_i;
        seen.value = scaled_value_i;
        predict_axis_word(seen);
      end
      if (out_valid_o && !out_stall_i) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_char_o, last_char_o));
        end else begin
          exp_c = text_q.pop_front();
          if (out_char_o !== exp_c.ch)
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      out_char_o, exp_c.ch));
          if (last_char_o !== exp_c.last)
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      last_char_o, exp_c.last));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int idle_tab[4];
    int stall_tab[4];
    logic [3:0] f;
    mismatches = 0;
    cur_idle   = 0;
    cur_stall  = 0;
    drain_next = 1'b0;
    idle_tab   = '{0, 46, 0, 18};
    stall_tab  = '{0, 0, 46, 18};

    // directed: zero, sign, missing integer part, trailing zeros, extremes,
    // fraction count saturation, axis letter extremes
    add_request("X", 4'd0, 48'd0);
    add_request("Y", 4'd9, 48'd0);
    add_request("Z", 4'd15, 48'd0);
    add_request("X", 4'd0, 48'd1);
    add_request("X", 4'd0, -48'sd1);
    add_request("E", 4'd1, 48'd5);
    add_request("E", 4'd1, -48'sd5);
    add_request("F", 4'd2, 48'd50);
    add_request("F", 4'd2, 48'd100);
    add_request("F", 4'd3, -48'sd1000);
    add_request("A", 4'd9, 48'd1);
    add_request("B", 4'd9, -48'sd123456789);
    add_request("C", 4'd3, 48'd1234567890);
    add_request("X", 4'd0, 48'h7FFF_FFFF_FFFF);
    add_request("Y", 4'd9, 48'h7FFF_FFFF_FFFF);
    add_request("Z", 4'd0, 48'h8000_0000_0000);
    add_request("Z", 4'd9, 48'h8000_0000_0000);
    add_request("I", 4'd10, 48'd1234567891);
    add_request("J", 4'd15, -48'sd1);
    add_request("K", 4'd12, 48'd1000000000);
    add_request(8'h00, 4'd4, 48'd12345);
    add_request(8'hFF, 4'd5, -48'sd100001);
    add_request("Q", 4'd8, 48'd99999999);

    // random phases, each opening on a drained block
    for (int p = 0; p < 4; p++) begin
      cur_idle   = idle_tab[p];
      cur_stall  = stall_tab[p];
      drain_next = 1'b1;
      repeat (50) begin
        f = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 9))
                                         : 4'($urandom_range(10, 15));
        add_request(8'($urandom_range(0, 255)), f, random_value());
      end
    end

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || in_valid_i || text_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("fixed_point_decimal_ascii_formatter regression: pass");
    else
      $display("fixed_point_decimal_ascii_formatter regression: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #4000000;
    $display("fixed_point_decimal_ascii_formatter regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/fpdaf_pkg.sv
hdl/fpdaf_dabble.sv
hdl/fixed_point_decimal_ascii_formatter.sv
tb/sv/fixed_point_decimal_ascii_formatter_tb.sv
